@@ sv/hacfp_pkg.sv @@
// Package for the hex ASCII command frame parser.
// Holds the parse phase type, the summary record, character constants and
// the hex digit decoder. It depends on nothing else.
`timescale 1ns / 1ps
`default_nettype none

package hacfp_pkg;

  localparam int unsigned CHAR_W       = 8;
  localparam int unsigned OPCODE_W     = 24;
  localparam int unsigned STATUS_W     = 8;
  localparam int unsigned LENGTH_W     = 16;
  localparam int unsigned COUNT_W      = 17;
  localparam int unsigned INDEX_W      = 3;
  localparam int unsigned SUMMARY_W    = 67;
  localparam int unsigned OUT_DATA_W   = 72;

  localparam logic [INDEX_W-1:0] OPCODE_LAST = INDEX_W'(6 - 1);
  localparam logic [INDEX_W-1:0] STATUS_LAST = INDEX_W'(2 - 1);
  localparam logic [INDEX_W-1:0] LENGTH_LAST = INDEX_W'(4 - 1);
  localparam logic [COUNT_W-1:0] COUNT_MAX   = {COUNT_W{1'b1}};

  localparam logic [CHAR_W-1:0] CHAR_SEVEN   = 8'h37;
  localparam logic [CHAR_W-1:0] CHAR_LOWER_E = 8'h65;
  localparam logic [CHAR_W-1:0] CHAR_ZERO    = 8'd48;
  localparam logic [CHAR_W-1:0] CHAR_NINE    = 8'd57;
  localparam logic [CHAR_W-1:0] CHAR_UPPER_A = 8'd65;
  localparam logic [CHAR_W-1:0] CHAR_UPPER_F = 8'd70;
  localparam logic [CHAR_W-1:0] CHAR_LOWER_A = 8'd97;
  localparam logic [CHAR_W-1:0] CHAR_LOWER_F = 8'd102;

  typedef enum logic [4:0] {
    PH_HUNT   = 5'b00001,
    PH_OPCODE = 5'b00010,
    PH_STATUS = 5'b00100,
    PH_LENGTH = 5'b01000,
    PH_PARAMS = 5'b10000
  } phase_t;

  typedef struct packed {
    logic                length_match;
    logic [LENGTH_W-1:0] param_bytes_seen;
    logic [LENGTH_W-1:0] declared_length;
    logic [STATUS_W-1:0] status_value;
    logic [OPCODE_W-1:0] opcode_value;
    logic                header_complete;
    logic                prefix_found;
  } summary_t;

  typedef struct packed {
    logic       is_hex;
    logic [3:0] nibble;
  } hex_digit_t;

  // Decodes one character into its nibble; is_hex is low for non-digits.
  function automatic hex_digit_t hex_decode(input logic [CHAR_W-1:0] c);
    hex_digit_t        r;
    logic [CHAR_W-1:0] diff;
    r    = '0;
    diff = '0;
    if (c >= CHAR_ZERO && c <= CHAR_NINE) begin
      diff     = c - CHAR_ZERO;
      r.is_hex = 1'b1;
      r.nibble = diff[3:0];
    end else if (c >= CHAR_UPPER_A && c <= CHAR_UPPER_F) begin
      diff     = c - CHAR_UPPER_A + 8'd10;
      r.is_hex = 1'b1;
      r.nibble = diff[3:0];
    end else if (c >= CHAR_LOWER_A && c <= CHAR_LOWER_F) begin
      diff     = c - CHAR_LOWER_A + 8'd10;
      r.is_hex = 1'b1;
      r.nibble = diff[3:0];
    end
    return r;
  endfunction

endpackage

`default_nettype wire

@@ sv/hacfp_core.sv @@
// Parse state and per-character update of the command frame parser.
// Depends on hacfp_pkg for the phase type, summary record and hex decoder.
`timescale 1ns / 1ps
`default_nettype none

module hacfp_core
  import hacfp_pkg::*;
(
  input  wire logic              clk,
  input  wire logic              rst,
  input  wire logic              step,
  input  wire logic [CHAR_W-1:0] char_code,
  input  wire logic              end_of_line,
  output summary_t               summary
);

  phase_t               phase, phase_next;
  logic                 seen_seven, seen_seven_next;
  logic [INDEX_W-1:0]   digit_index, digit_index_next;
  logic [OPCODE_W-1:0]  opcode_acc, opcode_acc_next;
  logic [STATUS_W-1:0]  status_acc, status_acc_next;
  logic [LENGTH_W-1:0]  length_acc, length_acc_next;
  logic [COUNT_W-1:0]   param_digit_count, param_digit_count_next;
  hex_digit_t           digit;
  logic                 prefix;
  logic                 complete;
  logic [LENGTH_W-1:0]  bytes;

  assign digit = hex_decode(char_code);

  always_comb begin
    phase_next             = phase;
    seen_seven_next        = seen_seven;
    digit_index_next       = digit_index;
    opcode_acc_next        = opcode_acc;
    status_acc_next        = status_acc;
    length_acc_next        = length_acc;
    param_digit_count_next = param_digit_count;
    unique case (phase)
      PH_HUNT: begin
        if (seen_seven && char_code == CHAR_LOWER_E) begin
          phase_next       = PH_OPCODE;
          seen_seven_next  = 1'b0;
          digit_index_next = '0;
        end else begin
          seen_seven_next = (char_code == CHAR_SEVEN);
        end
      end
      PH_OPCODE: begin
        if (digit.is_hex) begin
          opcode_acc_next = {opcode_acc[OPCODE_W-5:0], digit.nibble};
          if (digit_index == OPCODE_LAST) begin
            phase_next       = PH_STATUS;
            digit_index_next = '0;
          end else begin
            digit_index_next = digit_index + 1'b1;
          end
        end
      end
      PH_STATUS: begin
        if (digit.is_hex) begin
          status_acc_next = {status_acc[STATUS_W-5:0], digit.nibble};
          if (digit_index == STATUS_LAST) begin
            phase_next       = PH_LENGTH;
            digit_index_next = '0;
          end else begin
            digit_index_next = digit_index + 1'b1;
          end
        end
      end
      PH_LENGTH: begin
        if (digit.is_hex) begin
          length_acc_next = {length_acc[LENGTH_W-5:0], digit.nibble};
          if (digit_index == LENGTH_LAST) begin
            phase_next       = PH_PARAMS;
            digit_index_next = '0;
          end else begin
            digit_index_next = digit_index + 1'b1;
          end
        end
      end
      PH_PARAMS: begin
        if (digit.is_hex && param_digit_count != COUNT_MAX) begin
          param_digit_count_next = param_digit_count + 1'b1;
        end
      end
      default: begin
      end
    endcase
  end

  // The summary reflects the state after this character has been taken.
  assign prefix   = (phase_next != PH_HUNT);
  assign complete = (phase_next == PH_PARAMS);
  assign bytes    = complete ? param_digit_count_next[COUNT_W-1:1] : '0;

  always_comb begin
    summary                  = '0;
    summary.prefix_found     = prefix;
    summary.header_complete  = complete;
    summary.opcode_value     = prefix ? opcode_acc_next : '0;
    summary.status_value     = prefix ? status_acc_next : '0;
    summary.declared_length  = prefix ? length_acc_next : '0;
    summary.param_bytes_seen = bytes;
    summary.length_match     = complete && (bytes == length_acc_next);
  end

  always_ff @(posedge clk) begin
    if (rst || (step && end_of_line)) begin
      phase             <= PH_HUNT;
      seen_seven        <= 1'b0;
      digit_index       <= '0;
      opcode_acc        <= '0;
      status_acc        <= '0;
      length_acc        <= '0;
      param_digit_count <= '0;
    end else if (step) begin
      phase             <= phase_next;
      seen_seven        <= seen_seven_next;
      digit_index       <= digit_index_next;
      opcode_acc        <= opcode_acc_next;
      status_acc        <= status_acc_next;
      length_acc        <= length_acc_next;
      param_digit_count <= param_digit_count_next;
    end
  end

endmodule

`default_nettype wire

@@ sv/hex_ascii_command_frame_parser_unit.sv @@
// Top level of the hex ASCII command frame parser: input register, parse
// core and output register. Depends on hacfp_pkg and hacfp_core.
//
//  Channel | Direction | Handshake          | Payload
//  s_*     | in        | s_tvalid/s_tready  | s_tdata = char_code, s_tlast = end_of_line
//  m_*     | out       | m_tvalid/m_tready  | m_tdata = line summary, one per line end
//
// A character is held in the input register and is parsed there; a line
// end's summary is loaded into the output register at the edge that
// retires the character, and is offered on m_* from the output register.
// One character is taken per cycle while the output side keeps up.
// A pending line end waits in the input register only while the output
// register holds an untaken summary. Reset is synchronous and returns the
// parser to the prefix hunt with both registers empty.
`timescale 1ns / 1ps
`default_nettype none

module hex_ascii_command_frame_parser_unit
  import hacfp_pkg::*;
(
  input  wire logic                  clk,
  input  wire logic                  rst,
  input  wire logic                  s_tvalid,
  output logic                       s_tready,
  // s_tdata: [7:0] char_code
  input  wire logic [CHAR_W-1:0]     s_tdata,
  input  wire logic                  s_tlast,
  output logic                       m_tvalid,
  input  wire logic                  m_tready,
  // m_tdata: [0] prefix_found, [1] header_complete, [25:2] opcode_value,
  // [33:26] status_value, [49:34] declared_length, [65:50] param_bytes_seen,
  // [66] length_match, [71:67] zero
  output logic [OUT_DATA_W-1:0]      m_tdata
);

  logic              in_valid;
  logic [CHAR_W-1:0] in_char;
  logic              in_eol;
  logic              out_free;
  logic              in_advance;
  logic              step;
  summary_t          summary;
  summary_t          out_summary;

  assign out_free   = !m_tvalid || m_tready;
  assign in_advance = !in_eol || out_free;
  assign step       = in_valid && in_advance;
  assign s_tready   = !in_valid || in_advance;

  always_ff @(posedge clk) begin
    if (rst) begin
      in_valid <= 1'b0;
    end else if (s_tready) begin
      in_valid <= s_tvalid;
    end
  end

  always_ff @(posedge clk) begin
    if (s_tready) begin
      in_char <= s_tdata;
      in_eol  <= s_tlast;
    end
  end

  hacfp_core u_core (
    .clk         (clk),
    .rst         (rst),
    .step        (step),
    .char_code   (in_char),
    .end_of_line (in_eol),
    .summary     (summary)
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      m_tvalid <= 1'b0;
    end else if (step && in_eol) begin
      m_tvalid <= 1'b1;
    end else if (m_tready) begin
      m_tvalid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (step && in_eol) begin
      out_summary <= summary;
    end
  end

  assign m_tdata = {{(OUT_DATA_W - SUMMARY_W){1'b0}}, out_summary};

  a_complete_needs_prefix: assert property (@(posedge clk) disable iff (rst)
    m_tvalid |-> (!out_summary.header_complete || out_summary.prefix_found))
    else $error("header complete without prefix");

  a_match_needs_header: assert property (@(posedge clk) disable iff (rst)
    m_tvalid |-> (!out_summary.length_match || out_summary.header_complete))
    else $error("length match without complete header");

  a_no_prefix_zero_fields: assert property (@(posedge clk) disable iff (rst)
    (m_tvalid && !out_summary.prefix_found) |-> (m_tdata[OUT_DATA_W-1:1] == '0))
    else $error("nonzero fields without prefix");

  a_line_end_held: assert property (@(posedge clk) disable iff (rst)
    (in_valid && in_eol && !out_free) |=> (in_valid && in_eol))
    else $error("stalled line end lost");

endmodule

`default_nettype wire
